// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on clk_i, disabled in reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/csl_pkg.sv
// Types, codes and keyword table of the C-subset lexer
`default_nettype none
package csl_pkg;
  localparam int unsigned KwChars   = 8;
  localparam int unsigned LineBits  = 20;
  localparam int unsigned OffBits   = 24;
  localparam int unsigned NumKw     = 18;

  localparam logic [5:0] KindEof     = 6'd0;
  localparam logic [5:0] KindAssign  = 6'd9;
  localparam logic [5:0] KindEqEq    = 6'd10;
  localparam logic [5:0] KindInt     = 6'd15;
  localparam logic [5:0] KindIdent   = 6'd16;
  localparam logic [5:0] KindUnknown = 6'd17;
  localparam logic [5:0] KindKw0     = 6'd18;

  typedef enum logic [1:0] {ModeIdle, ModeIdent, ModeNumber, ModeEquals} mode_e;
  typedef enum logic [1:0] {BaseDec, BaseHex, BaseBin, BaseOct} base_e;
  typedef enum logic [1:0] {PhFirst, PhDigits, PhAfterU, PhAfterL} phase_e;

  typedef struct packed {
    logic [5:0]         token_kind;
    logic [LineBits-1:0] token_line;
    logic [15:0]        token_column;
    logic [63:0]        literal_value;
    logic               long_literal;
    logic               signed_literal;
    logic [OffBits-1:0] name_offset;
    logic [15:0]        name_length;
    logic               last_of_run;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } tok_slot_t;

  // keyword text packed first character in the low byte, zero padded
  function automatic logic [8*KwChars-1:0] kw_text(input logic [4:0] k);
    logic [8*KwChars-1:0] t;
    t = '0;
    unique case (k)
      5'd0:  t[47:0] = "nruter";
      5'd1:  t[15:0] = "fi";
      5'd2:  t[15:0] = "od";
      5'd3:  t[39:0] = "elihw";
      5'd4:  t[23:0] = "rof";
      5'd5:  t[47:0] = "hctiws";
      5'd6:  t[63:0] = "eunitnoc";
      5'd7:  t[39:0] = "kaerb";
      5'd8:  t[39:0] = "tsnoc";
      5'd9:  t[31:0] = "diov";
      5'd10: t[23:0] = "tni";
      5'd11: t[47:0] = "dengis";
      5'd12: t[63:0] = "dengisnu";
      5'd13: t[31:0] = "gnol";
      5'd14: t[39:0] = "trohs";
      5'd15: t[31:0] = "rahc";
      5'd16: t[39:0] = "taolf";
      5'd17: t[47:0] = "elbuod";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    logic [3:0] l;
    unique case (k)
      5'd1, 5'd2: l = 4'd2;
      5'd4, 5'd10: l = 4'd3;
      5'd9, 5'd13, 5'd15: l = 4'd4;
      5'd3, 5'd7, 5'd8, 5'd14, 5'd16: l = 4'd5;
      5'd0, 5'd5, 5'd11, 5'd17: l = 4'd6;
      5'd6, 5'd12: l = 4'd8;
      default: l = 4'd0;
    endcase
    return l;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/csl_byte_if.sv
// Valid/ready channels for source bytes and tokens
`default_nettype none
interface csl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface csl_tok_if;
  logic             valid;
  logic             ready;
  csl_pkg::token_t  tok;
  modport source (output valid, output tok, input ready);
  modport sink (input valid, input tok, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/csl_kw_match.sv
// Parallel keyword match over the word buffer
`default_nettype none
module csl_kw_match (
  input  wire logic [8*csl_pkg::KwChars-1:0] chars_i,
  input  wire logic [15:0]                   len_i,
  output logic                               hit_o,
  output logic [5:0]                         kind_o
);
  import csl_pkg::*;
  logic [NumKw-1:0] hits;
  always_comb begin
    for (int k = 0; k < NumKw; k++) begin
      hits[k] = (len_i == {12'd0, kw_len(5'(k))}) && (chars_i == kw_text(5'(k)));
    end
    hit_o  = |hits;
    kind_o = KindIdent;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (hits[k]) kind_o = KindKw0 + 6'(k);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/csl_out_queue.sv
// Four-entry token queue between the scanner and the output channel
`default_nettype none
`include "assert_macros.svh"
module csl_out_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire csl_pkg::tok_slot_t a_i,
  input  wire csl_pkg::tok_slot_t b_i,
  output logic                    room_o,
  csl_tok_if.source               out_o
);
  import csl_pkg::*;
  token_t     mem_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic [1:0] n_in;
  logic       pop;

  assign pop       = out_o.valid && out_o.ready;
  assign n_in      = {1'b0, a_i.valid} + {1'b0, b_i.valid};
  assign out_o.valid = cnt_q != 3'd0;
  assign out_o.tok   = mem_q[rd_q];
  // room for a worst-case two-token byte once this cycle's pop is counted
  assign room_o    = (cnt_q - {2'b0, pop}) <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (a_i.valid) mem_q[wr_q] <= a_i.tok;
    if (b_i.valid) mem_q[a_i.valid ? wr_q + 2'd1 : wr_q] <= b_i.tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_in;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, n_in} - {2'b0, pop};
    end
  end

  `ASSERT_CLK(a_no_overflow, cnt_q <= 3'd4)
  `ASSERT_CLK(a_pop_nonempty, pop |-> cnt_q != 3'd0)
  `ASSERT_CLK(a_push_room, (a_i.valid || b_i.valid) |-> (cnt_q - {2'b0, pop}) <= 3'd2)
endmodule
`default_nettype wire

// File: hw/rtl/csl_scanner.sv
// Per-byte scanner state and token generation
`default_nettype none
`include "assert_macros.svh"
module csl_scanner (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire logic [7:0]         c_i,
  output csl_pkg::tok_slot_t      a_o,
  output csl_pkg::tok_slot_t      b_o
);
  import csl_pkg::*;
  localparam logic [LineBits-1:0] LineMax = '1;
  localparam logic [OffBits-1:0]  OffMax  = '1;

  mode_e  mode_q, mode_d;
  base_e  base_q, base_d;
  phase_e ph_q, ph_d;
  logic   bad_q, bad_d, uns_q, uns_d, lng_q, lng_d;
  logic [OffBits-1:0]  off_q, off_d, soff_q, soff_d;
  logic [LineBits-1:0] line_q, line_d, sline_q, sline_d;
  logic [15:0]         col_q, col_d, scol_q, scol_d, wlen_q, wlen_d;
  logic [8*KwChars-1:0] w_q, w_d;
  logic [63:0]         val_q, val_d;
  tok_slot_t a_d, b_d;

  logic kw_hit;
  logic [5:0] kw_kind;
  csl_kw_match u_kw (.chars_i(w_q), .len_i(wlen_q), .hit_o(kw_hit), .kind_o(kw_kind));

  function automatic token_t mk(input logic [5:0] k, input logic [LineBits-1:0] l,
                                input logic [15:0] c);
    token_t t;
    t = '0;
    t.token_kind = k; t.token_line = l; t.token_column = c;
    return t;
  endfunction

  logic alpha, digit, wbyte, hexl, hexu;
  logic [3:0] dv;
  logic [63:0] mul;
  token_t flush_t;
  logic   flush_v;

  always_comb begin
    alpha = (c_i >= "a" && c_i <= "z") || (c_i >= "A" && c_i <= "Z") || c_i == "_";
    digit = c_i >= "0" && c_i <= "9";
    wbyte = alpha || digit;
    hexl  = c_i >= "a" && c_i <= "f";
    hexu  = c_i >= "A" && c_i <= "F";
    dv = digit ? 4'(c_i - "0") : hexl ? 4'(c_i - "a" + 8'd10) : 4'(c_i - "A" + 8'd10);
    unique case (base_q)
      BaseHex: mul = {val_q[59:0], 4'd0};
      BaseBin: mul = {val_q[62:0], 1'b0};
      BaseOct: mul = {val_q[60:0], 3'd0};
      default: mul = {val_q[60:0], 3'd0} + {val_q[62:0], 1'b0};
    endcase

    // pending token flushed by a byte that cannot extend it
    flush_v = 1'b0;
    flush_t = mk(KindAssign, sline_q, scol_q);
    unique case (mode_q)
      ModeIdent: begin
        flush_v = 1'b1;
        flush_t = mk(kw_kind, sline_q, scol_q);
        if (!kw_hit) begin
          flush_t.name_offset = soff_q;
          flush_t.name_length = wlen_q;
        end
      end
      ModeNumber: begin
        flush_v = 1'b1;
        if (bad_q) flush_t = mk(KindUnknown, sline_q, scol_q);
        else begin
          flush_t = mk(KindInt, sline_q, scol_q);
          flush_t.literal_value  = val_q;
          flush_t.long_literal   = lng_q;
          flush_t.signed_literal = !uns_q;
        end
      end
      ModeEquals: flush_v = 1'b1;
      default: flush_v = 1'b0;
    endcase

    mode_d = mode_q; base_d = base_q; ph_d = ph_q;
    bad_d = bad_q; uns_d = uns_q; lng_d = lng_q;
    off_d = off_q; soff_d = soff_q; line_d = line_q; sline_d = sline_q;
    col_d = col_q; scol_d = scol_q; wlen_d = wlen_q; w_d = w_q; val_d = val_q;
    a_d = '0; b_d = '0;

    if (fire_i) begin
      off_d = (off_q == OffMax) ? off_q : off_q + 1'b1;
      col_d = (col_q == 16'hFFFF) ? col_q : col_q + 16'd1;
      if (c_i == 8'h0A) begin
        line_d = (line_q == LineMax) ? line_q : line_q + 1'b1;
        col_d  = '0;
      end
      if (mode_q == ModeIdent && wbyte) begin
        for (int i = 0; i < KwChars; i++)
          if (wlen_q == 16'(i)) w_d[8*i +: 8] = c_i;
        wlen_d = (wlen_q == 16'hFFFF) ? wlen_q : wlen_q + 16'd1;
      end else if (mode_q == ModeNumber && wbyte) begin
        if (!bad_q) begin
          priority if (ph_q == PhFirst && (c_i == "x" || c_i == "X")) begin
            ph_d = PhDigits; base_d = BaseHex;
          end else if (ph_q == PhFirst && (c_i == "b" || c_i == "B")) begin
            ph_d = PhDigits; base_d = BaseBin;
          end else if (ph_q == PhFirst || ph_q == PhDigits) begin
            // first digit after a leading zero selects octal
            ph_d = PhDigits;
            if (digit || ((base_q == BaseHex) && ph_q == PhDigits && (hexl || hexu))) begin
              if (ph_q == PhFirst) begin
                base_d = BaseOct;
                if (dv >= 4'd8) bad_d = 1'b1;
                else val_d = {val_q[60:0], 3'd0} + 64'(dv);
              end else begin
                unique case (base_q)
                  BaseBin: bad_d = dv >= 4'd2;
                  BaseOct: bad_d = dv >= 4'd8;
                  BaseDec: bad_d = 1'b0;
                  default: bad_d = 1'b0;
                endcase
                if (!bad_d) val_d = mul + 64'(dv);
              end
            end else begin
              if (ph_q == PhFirst) base_d = BaseOct;
              if (c_i == "u" || c_i == "U") begin uns_d = 1'b1; ph_d = PhAfterU; end
              else if (c_i == "l" || c_i == "L") begin lng_d = 1'b1; ph_d = PhAfterL; end
              else bad_d = 1'b1;
            end
          end else if (ph_q == PhAfterU && (c_i == "l" || c_i == "L")) begin
            lng_d = 1'b1; ph_d = PhAfterL;
          end else begin
            bad_d = 1'b1;
          end
        end
      end else if (mode_q == ModeEquals && c_i == "=") begin
        a_d.valid = 1'b1;
        a_d.tok   = mk(KindEqEq, sline_q, scol_q);
        a_d.tok.last_of_run = 1'b1;
        mode_d = ModeIdle;
      end else begin
        a_d.valid = flush_v;
        a_d.tok   = flush_t;
        mode_d  = ModeIdle;
        sline_d = line_q; scol_d = col_d; soff_d = off_q;
        if (c_i == 8'h0A) scol_d = col_d;
        b_d.tok = mk(KindUnknown, line_d, col_d);
        unique case (c_i)
          8'h00: begin
            b_d.valid = 1'b1;
            b_d.tok   = mk(KindEof, line_d, col_d);
            mode_d = ModeIdle; base_d = BaseDec; ph_d = PhFirst;
            bad_d = 1'b0; uns_d = 1'b0; lng_d = 1'b0;
            off_d = '0; soff_d = '0; line_d = LineBits'(1); sline_d = LineBits'(1);
            col_d = '0; scol_d = '0; wlen_d = '0; w_d = '0; val_d = '0;
          end
          " ", 8'h09, 8'h0A, 8'h0D: b_d.valid = 1'b0;
          ";": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd1; end
          "(": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd2; end
          ")": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd3; end
          "{": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd4; end
          "}": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd5; end
          "[": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd6; end
          "]": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd7; end
          ",": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd8; end
          "+": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd11; end
          "-": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd12; end
          "*": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd13; end
          "/": begin b_d.valid = 1'b1; b_d.tok.token_kind = 6'd14; end
          "=": mode_d = ModeEquals;
          default: begin
            if (digit) begin
              mode_d = ModeNumber; bad_d = 1'b0; uns_d = 1'b0; lng_d = 1'b0;
              base_d = BaseDec; val_d = 64'(dv);
              ph_d = (c_i == "0") ? PhFirst : PhDigits;
            end else if (alpha) begin
              mode_d = ModeIdent;
              w_d = {{(8*KwChars-8){1'b0}}, c_i};
              wlen_d = 16'd1;
            end else begin
              b_d.valid = 1'b1;
            end
          end
        endcase
        // mark the final token of this byte
        if (b_d.valid) b_d.tok.last_of_run = 1'b1;
        else if (a_d.valid) a_d.tok.last_of_run = 1'b1;
      end
    end
  end

  assign a_o = a_d;
  assign b_o = b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle; base_q <= BaseDec; ph_q <= PhFirst;
      bad_q <= 1'b0; uns_q <= 1'b0; lng_q <= 1'b0;
      off_q <= '0; soff_q <= '0; line_q <= LineBits'(1); sline_q <= LineBits'(1);
      col_q <= '0; scol_q <= '0; wlen_q <= '0; w_q <= '0; val_q <= '0;
    end else begin
      mode_q <= mode_d; base_q <= base_d; ph_q <= ph_d;
      bad_q <= bad_d; uns_q <= uns_d; lng_q <= lng_d;
      off_q <= off_d; soff_q <= soff_d; line_q <= line_d; sline_q <= sline_d;
      col_q <= col_d; scol_q <= scol_d; wlen_q <= wlen_d; w_q <= w_d; val_q <= val_d;
    end
  end

  `ASSERT_CLK(a_b_last, b_o.valid |-> b_o.tok.last_of_run)
  `ASSERT_CLK(a_line_nonzero, line_q != '0)
endmodule
`default_nettype wire

// File: hw/rtl/c_subset_token_lexer.sv
// Top level of the C-subset token lexer
// Throughput: one source byte per cycle while ready is high; up to two tokens per byte.
// Tokens are queued in registers and drained one per cycle while the sink is ready.
// Ready drops while the four-entry token queue could not take two more tokens.
// Reset: asynchronous active low; positions return to line 1, column 0, offset 0.
`default_nettype none
module c_subset_token_lexer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csl_byte_if.sink  in_i,
  csl_tok_if.source out_o
);
  import csl_pkg::*;
  tok_slot_t a, b;
  logic room, fire;

  assign in_i.ready = room;
  assign fire = in_i.valid && room;

  csl_scanner u_scan (
    .clk_i, .rst_ni, .fire_i(fire), .c_i(in_i.source_byte), .a_o(a), .b_o(b)
  );
  csl_out_queue u_q (.clk_i, .rst_ni, .a_i(a), .b_i(b), .room_o(room), .out_o(out_o));
endmodule
`default_nettype wire

// File: dv/c_subset_token_lexer_tb.sv
// C-subset token lexer testbench: directed and random byte streams checked against a predictor
`default_nettype none
module c_subset_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csl_pkg::*;

  localparam int unsigned WatchLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  csl_byte_if in_if ();
  csl_tok_if  out_if ();

  c_subset_token_lexer u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // lexer state mirrored for prediction
  mode_e              lx_mode;
  logic [OffBits-1:0] lx_off;
  logic [LineBits-1:0] lx_line;
  logic [15:0]        lx_col;
  logic [LineBits-1:0] st_line;
  logic [15:0]        st_col;
  logic [OffBits-1:0] st_off;
  logic [7:0]         word_buf [KwChars];
  logic [15:0]        word_len;
  logic [63:0]        num_val;
  base_e              num_base;
  phase_e             num_phase;
  logic               num_bad, num_uns, num_long;

  token_t expected_tokens [$];
  logic [7:0] pending_bytes [$];
  int unsigned errors = 0;
  int unsigned tokens_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  bit hold_send = 1'b0;
  bit in_taken = 1'b0;

  task automatic lexer_clear();
    lx_mode = ModeIdle; lx_off = '0; lx_line = 1; lx_col = '0;
    st_line = 1; st_col = '0; st_off = '0;
    for (int i = 0; i < KwChars; i++) word_buf[i] = '0;
    word_len = '0; num_val = '0; num_base = BaseDec; num_phase = PhFirst;
    num_bad = 0; num_uns = 0; num_long = 0;
  endtask

  task automatic push_token(input logic [5:0] kind, input logic [LineBits-1:0] ln,
                            input logic [15:0] cl, input logic [63:0] v = '0,
                            input logic lg = 0, input logic sg = 0,
                            input logic [OffBits-1:0] of = '0, input logic [15:0] len = '0);
    token_t t;
    t = '{kind, ln, cl, v, lg, sg, of, len, 1'b0};
    expected_tokens.push_back(t);
  endtask

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] keyword_kind();
    string kws [NumKw] = '{"return", "if", "do", "while", "for", "switch", "continue",
      "break", "const", "void", "int", "signed", "unsigned", "long", "short", "char",
      "float", "double"};
    bit hit;
    for (int k = 0; k < NumKw; k++) begin
      if (word_len == kws[k].len()) begin
        hit = 1;
        for (int i = 0; i < kws[k].len(); i++)
          if (word_buf[i] != kws[k][i]) hit = 0;
        if (hit) return KindKw0 + 6'(k);
      end
    end
    return KindIdent;
  endfunction

  task automatic flush_word();
    logic [5:0] k;
    case (lx_mode)
      ModeIdent: begin
        k = keyword_kind();
        if (k == KindIdent) push_token(k, st_line, st_col, 0, 0, 0, st_off, word_len);
        else push_token(k, st_line, st_col);
      end
      ModeNumber: begin
        if (num_bad) push_token(KindUnknown, st_line, st_col);
        else push_token(KindInt, st_line, st_col, num_val, num_long, !num_uns);
      end
      ModeEquals: push_token(KindAssign, st_line, st_col);
      default: ;
    endcase
    lx_mode = ModeIdle;
  endtask

  task automatic feed_digit(input logic [7:0] c);
    logic [4:0] dv;
    logic [63:0] r;
    bit have;
    have = 0; dv = 0;
    if (num_bad) return;
    if (num_phase == PhFirst) begin
      num_phase = PhDigits;
      if (c == "x" || c == "X") begin num_base = BaseHex; return; end
      if (c == "b" || c == "B") begin num_base = BaseBin; return; end
      num_base = BaseOct;
    end
    if (num_phase == PhDigits) begin
      if (is_dig(c)) begin dv = c - "0"; have = 1; end
      else if (num_base == BaseHex && c >= "a" && c <= "f") begin dv = c - "a" + 10; have = 1; end
      else if (num_base == BaseHex && c >= "A" && c <= "F") begin dv = c - "A" + 10; have = 1; end
      if (have) begin
        case (num_base)
          BaseHex: r = 16;
          BaseBin: r = 2;
          BaseOct: r = 8;
          default: r = 10;
        endcase
        if (dv >= r) num_bad = 1;
        else num_val = num_val * r + dv;
        return;
      end
      if (c == "u" || c == "U") begin num_uns = 1; num_phase = PhAfterU; return; end
      if (c == "l" || c == "L") begin num_long = 1; num_phase = PhAfterL; return; end
      num_bad = 1;
      return;
    end
    if (num_phase == PhAfterU && (c == "l" || c == "L")) begin
      num_long = 1; num_phase = PhAfterL; return;
    end
    num_bad = 1;
  endtask

  // predict the tokens caused by one accepted byte
  task automatic lex_byte(input logic [7:0] c);
    logic [OffBits-1:0] here;
    int n0;
    bit wb;
    here = lx_off;
    n0 = expected_tokens.size();
    wb = is_alpha(c) || is_dig(c);
    if (lx_off != '1) lx_off++;
    if (lx_col != '1) lx_col++;
    if (c == 8'h0a) begin
      if (lx_line != '1) lx_line++;
      lx_col = '0;
    end
    if (lx_mode == ModeIdent && wb) begin
      if (word_len < KwChars) word_buf[word_len] = c;
      if (word_len != '1) word_len++;
      return;
    end
    if (lx_mode == ModeNumber && wb) begin
      feed_digit(c);
      return;
    end
    if (lx_mode == ModeEquals && c == "=") begin
      push_token(KindEqEq, st_line, st_col);
      lx_mode = ModeIdle;
    end else begin
      flush_word();
      st_line = lx_line; st_col = lx_col; st_off = here;
      case (c)
        8'h00: begin
          push_token(KindEof, lx_line, lx_col);
          lexer_clear();
        end
        " ", 8'h09, 8'h0a, 8'h0d: ;
        ";": push_token(1, lx_line, lx_col);
        "(": push_token(2, lx_line, lx_col);
        ")": push_token(3, lx_line, lx_col);
        "{": push_token(4, lx_line, lx_col);
        "}": push_token(5, lx_line, lx_col);
        "[": push_token(6, lx_line, lx_col);
        "]": push_token(7, lx_line, lx_col);
        ",": push_token(8, lx_line, lx_col);
        "+": push_token(11, lx_line, lx_col);
        "-": push_token(12, lx_line, lx_col);
        "*": push_token(13, lx_line, lx_col);
        "/": push_token(14, lx_line, lx_col);
        "=": lx_mode = ModeEquals;
        default: begin
          if (is_dig(c)) begin
            lx_mode = ModeNumber; num_bad = 0; num_uns = 0; num_long = 0;
            num_base = BaseDec; num_val = c - "0";
            num_phase = (c == "0") ? PhFirst : PhDigits;
          end else if (is_alpha(c)) begin
            lx_mode = ModeIdent;
            for (int i = 0; i < KwChars; i++) word_buf[i] = '0;
            word_buf[0] = c; word_len = 1;
          end else push_token(KindUnknown, lx_line, lx_col);
        end
      endcase
    end
    if (expected_tokens.size() > n0)
      expected_tokens[expected_tokens.size()-1].last_of_run = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch on token %0d: %s got 0x%0h expected 0x%0h", tokens_seen, what, got, want);
  endtask

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // driver: present one pending byte at a time, changes at the falling edge
  int unsigned send_gap = 0;
  initial begin
    in_if.valid = 1'b0;
    in_if.source_byte = '0;
    out_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        lex_byte(in_if.source_byte);
        bytes_sent++;
        void'(pending_bytes.pop_front());
        send_gap = gap_len();
      end
      if (in_if.valid && !in_taken) begin
        // hold the transaction until taken
      end else if (send_gap > 0 || hold_send || pending_bytes.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid <= 1'b1;
        in_if.source_byte <= pending_bytes[0];
      end
      out_if.ready <= ($urandom_range(0, 9) < 7) ||
                      (idle_cycles > 200);
    end
  end

  // monitor: sample at the rising edge
  always @(posedge clk_i) begin
    token_t got, want;
    if (rst_ni) begin
      in_taken = in_if.valid && in_if.ready;
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog expired with %0d tokens outstanding", expected_tokens.size());
        $display("FAILURE");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.tok;
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          errors++;
          $display("unexpected token kind %0d", got.token_kind);
        end else begin
          want = expected_tokens.pop_front();
          if (got.token_kind != want.token_kind)
            report_mismatch("token_kind", got.token_kind, want.token_kind);
          if (got.token_line != want.token_line)
            report_mismatch("token_line", got.token_line, want.token_line);
          if (got.token_column != want.token_column)
            report_mismatch("token_column", got.token_column, want.token_column);
          if (got.literal_value != want.literal_value)
            report_mismatch("literal_value", got.literal_value, want.literal_value);
          if (got.long_literal != want.long_literal)
            report_mismatch("long_literal", got.long_literal, want.long_literal);
          if (got.signed_literal != want.signed_literal)
            report_mismatch("signed_literal", got.signed_literal, want.signed_literal);
          if (got.name_offset != want.name_offset)
            report_mismatch("name_offset", got.name_offset, want.name_offset);
          if (got.name_length != want.name_length)
            report_mismatch("name_length", got.name_length, want.name_length);
          if (got.last_of_run != want.last_of_run)
            report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
        end
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  function automatic string random_word();
    string kws [NumKw] = '{"return", "if", "do", "while", "for", "switch", "continue",
      "break", "const", "void", "int", "signed", "unsigned", "long", "short", "char",
      "float", "double"};
    string pre [6] = '{"0x", "0X", "0b", "0B", "0", ""};
    string sfx [7] = '{"", "u", "U", "l", "L", "ul", "UL"};
    string alnum = "abcdefABCDEFxyzXYZ_0123456789lLuUgG";
    string dec_digits = "0123456789";
    string hex_digits = "0123456789abcdefABCDEF";
    string bin_digits = "01";
    string oct_digits = "01234567";
    string s;
    int n;
    case ($urandom_range(0, 5))
      0, 1: s = kws[$urandom_range(0, NumKw-1)];
      2: begin
        s = "";
        s = {s, string'(alnum[$urandom_range(0, 9)])};
        n = $urandom_range(0, 11);
        for (int i = 0; i < n; i++) s = {s, string'(alnum[$urandom_range(0, alnum.len()-1)])};
      end
      3: begin
        s = pre[$urandom_range(0, 5)];
        n = $urandom_range(0, 22);
        if (s == "") s = {s, string'(dec_digits[$urandom_range(1, 9)])};
        for (int i = 0; i < n; i++)
          s = {s, string'((s[1] == "x" || s[1] == "X") ?
                  hex_digits[$urandom_range(0, 21)] :
                  (s[1] == "b" || s[1] == "B") ? bin_digits[$urandom_range(0, 1)] :
                  oct_digits[$urandom_range(0, 7)])};
        s = {s, sfx[$urandom_range(0, 6)]};
      end
      4: begin
        s = "";
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          s = {s, string'(alnum[$urandom_range(18, alnum.len()-1)])};
      end
      default: s = "=";
    endcase
    return s;
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_if.valid || expected_tokens.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    string punct;
    punct = ";(){}[],=+-*/ \t\r\n";
    lexer_clear();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: keywords, equals forms, literal bases, bare prefixes, bad literals
    queue_text("unsigned x==0x1FuL;\n");
    queue_text("a=b 0b101 017 09 0x 0b 12ul 7lu {}[](),+-*/ continue\t");
    pending_bytes.push_back(8'hff);
    pending_bytes.push_back(8'h80);
    pending_bytes.push_back(8'h7f);
    pending_bytes.push_back(8'h00);
    queue_text("0xFFFFFFFFFFFFFFFFF1 == doubles\r");
    pending_bytes.push_back(8'h00);
    wait_drained();

    // random: mostly well-formed token streams, a little raw noise
    while (pending_bytes.size() + bytes_sent < 1950) begin
      case ($urandom_range(0, 19))
        0: pending_bytes.push_back($urandom_range(0, 255));
        1: pending_bytes.push_back(8'h00);
        2, 3, 4, 5, 6: pending_bytes.push_back(punct[$urandom_range(0, punct.len()-1)]);
        default: begin
          queue_text(random_word());
          if ($urandom_range(0, 2) == 0)
            pending_bytes.push_back(punct[$urandom_range(0, punct.len()-1)]);
        end
      endcase
      if (pending_bytes.size() > 60 && $urandom_range(0, 3) == 0) begin
        while (pending_bytes.size() != 0) @(posedge clk_i);
        if ($urandom_range(0, 5) == 0) begin
          // pause the sender until every token is out
          hold_send = 1'b1;
          wait_drained();
          hold_send = 1'b0;
        end
      end
    end
    pending_bytes.push_back(8'h00);
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("sent %0d source bytes, checked %0d tokens", bytes_sent, tokens_seen);
    $display("covered keywords, literal bases and suffixes, equals lookahead, eof, noise");
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
